// ===== src/bbuart_pkg.sv =====
// Package for the 8N1 UART channel with receive and transmit ring FIFOs.
// Holds the sizes, the event codes, the FIFO control and status records and the ring helpers.
// Used by bbuart_fifo, bbuart_engine and the top level; depends on nothing.
`default_nettype none

package bbuart_pkg;

    localparam int FIFO_DEPTH = 512;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = 9;
    localparam int COUNT_MAX  = 511;
    localparam int FRAME_BITS = 10;
    localparam int BITS_W     = 4;
    localparam int BYTE_W     = 8;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_EDGE = 2'd1,
        FUNC_PUSH = 2'd2,
        FUNC_POP  = 2'd3
    } t_func;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctrl;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [COUNT_W-1:0] count;
    } t_fifo_stat;

    typedef struct packed {
        logic               tx_level;
        logic [BYTE_W-1:0]  rx_data;
        logic               rx_data_valid;
        logic               push_accepted;
        logic               rx_frame_dropped;
        logic               busy_res;
        logic [COUNT_W-1:0] rx_count;
        logic [COUNT_W-1:0] tx_count;
    } t_result;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] rd,
                                                     input logic [PTR_W-1:0] wr);
        return (wr >= rd) ? (wr - rd) : PTR_W'(FIFO_DEPTH - int'(rd) + int'(wr));
    endfunction

    function automatic logic [COUNT_W-1:0] sat_count(input logic [PTR_W-1:0] c);
        return (int'(c) > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(c);
    endfunction

endpackage

`default_nettype wire

// ===== src/bbuart_fifo.sv =====
// Ring FIFO of bytes with one slot kept empty and a prefetched head byte.
// The memory read is registered; a write to the slot being prefetched is bypassed.
// Depends on bbuart_pkg.
`default_nettype none

module bbuart_fifo (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  bbuart_pkg::t_fifo_ctrl           i_ctrl,
    input  wire  [bbuart_pkg::BYTE_W-1:0]    i_wdata,
    output bbuart_pkg::t_fifo_stat           o_stat,
    output logic [bbuart_pkg::BYTE_W-1:0]    o_head
);

    logic [bbuart_pkg::BYTE_W-1:0] r_mem [bbuart_pkg::FIFO_DEPTH];
    logic [bbuart_pkg::PTR_W-1:0]  r_rd;
    logic [bbuart_pkg::PTR_W-1:0]  r_wr;
    logic [bbuart_pkg::PTR_W-1:0]  n_rd;
    logic [bbuart_pkg::PTR_W-1:0]  n_wr;
    logic [bbuart_pkg::BYTE_W-1:0] r_q;
    logic [bbuart_pkg::BYTE_W-1:0] r_bdata;
    logic                          r_byp;

    always_comb begin
        n_rd = i_ctrl.pop  ? bbuart_pkg::ring_next(r_rd) : r_rd;
        n_wr = i_ctrl.push ? bbuart_pkg::ring_next(r_wr) : r_wr;
    end

    always_comb begin
        o_stat.empty = (r_rd == r_wr);
        o_stat.full  = (bbuart_pkg::ring_count(r_rd, r_wr)
                        == bbuart_pkg::PTR_W'(bbuart_pkg::FIFO_DEPTH - 1));
        o_stat.count = bbuart_pkg::sat_count(bbuart_pkg::ring_count(r_rd, r_wr));
        o_head       = r_byp ? r_bdata : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[r_wr] <= i_wdata;
        end
        r_q     <= r_mem[n_rd];
        r_byp   <= i_ctrl.push && (r_wr == n_rd);
        r_bdata <= i_wdata;
    end

endmodule

`default_nettype wire

// ===== src/bbuart_engine.sv =====
// Event logic of the UART channel: tick timer, receive shifter and transmit framer.
// Turns one event into FIFO pushes and pops and one result record.
// Depends on bbuart_pkg; the FIFOs sit beside it in the top level.
`default_nettype none

module bbuart_engine (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_fire,
    input  bbuart_pkg::t_func                i_func,
    input  wire                              i_rx_level,
    input  wire                              i_open,
    input  bbuart_pkg::t_fifo_stat           i_rx_stat,
    input  bbuart_pkg::t_fifo_stat           i_tx_stat,
    input  wire  [bbuart_pkg::BYTE_W-1:0]    i_rx_head,
    input  wire  [bbuart_pkg::BYTE_W-1:0]    i_tx_head,
    output bbuart_pkg::t_fifo_ctrl           o_rx_ctrl,
    output bbuart_pkg::t_fifo_ctrl           o_tx_ctrl,
    output logic [bbuart_pkg::BYTE_W-1:0]    o_rx_wdata,
    output bbuart_pkg::t_result              o_result
);

    logic [bbuart_pkg::FRAME_BITS-1:0] r_rx_shift;
    logic [bbuart_pkg::FRAME_BITS-1:0] n_rx_shift;
    logic [bbuart_pkg::BITS_W-1:0]     r_rx_bits;
    logic [bbuart_pkg::BITS_W-1:0]     n_rx_bits;
    logic [bbuart_pkg::FRAME_BITS-1:0] r_tx_frame;
    logic [bbuart_pkg::FRAME_BITS-1:0] n_tx_frame;
    logic [bbuart_pkg::BITS_W-1:0]     r_tx_bits;
    logic [bbuart_pkg::BITS_W-1:0]     n_tx_bits;
    logic                              r_tx_pin;
    logic                              n_tx_pin;
    logic                              r_armed;
    logic                              n_armed;
    logic                              r_phase;
    logic                              n_phase;
    logic                              pending;
    bbuart_pkg::t_fifo_ctrl            rx_ctrl;
    bbuart_pkg::t_fifo_ctrl            tx_ctrl;

    always_comb begin
        n_rx_shift = r_rx_shift;
        n_rx_bits  = r_rx_bits;
        n_tx_frame = r_tx_frame;
        n_tx_bits  = r_tx_bits;
        n_tx_pin   = r_tx_pin;
        n_armed    = r_armed;
        n_phase    = r_phase;
        pending    = 1'b0;
        rx_ctrl    = '0;
        tx_ctrl    = '0;
        o_rx_wdata = '0;
        o_result   = '0;

        unique case (i_func)
            bbuart_pkg::FUNC_TICK: begin
                if (r_armed) begin
                    if (i_open && !r_phase) begin
                        if (r_rx_bits != '0) begin
                            n_rx_bits  = r_rx_bits - bbuart_pkg::BITS_W'(1);
                            n_rx_shift = {i_rx_level,
                                          r_rx_shift[bbuart_pkg::FRAME_BITS-1:1]};
                            if (n_rx_bits == '0) begin
                                if (i_rx_level && !i_rx_stat.full) begin
                                    rx_ctrl.push = 1'b1;
                                    o_rx_wdata   = n_rx_shift[bbuart_pkg::BYTE_W:1];
                                end else begin
                                    o_result.rx_frame_dropped = 1'b1;
                                end
                                n_rx_shift = '0;
                            end
                        end
                        if (!i_tx_stat.empty) begin
                            if (r_tx_bits == '0) begin
                                n_tx_frame = {1'b1, i_tx_head, 1'b0};
                                n_tx_bits  = bbuart_pkg::BITS_W'(bbuart_pkg::FRAME_BITS);
                            end
                            n_tx_pin  = n_tx_frame[bbuart_pkg::BITS_W'(bbuart_pkg::FRAME_BITS)
                                                   - n_tx_bits];
                            n_tx_bits = n_tx_bits - bbuart_pkg::BITS_W'(1);
                            if (n_tx_bits == '0) begin
                                tx_ctrl.pop = 1'b1;
                            end
                        end
                    end
                    pending = i_open && (n_rx_bits != '0 || n_tx_bits != '0
                                         || (i_tx_stat.count
                                             - bbuart_pkg::COUNT_W'(tx_ctrl.pop)) != '0);
                    n_phase = ~r_phase;
                    if (!pending) begin
                        n_armed = 1'b0;
                        n_phase = 1'b0;
                    end
                end
            end
            bbuart_pkg::FUNC_EDGE: begin
                if (i_open && r_rx_bits == '0) begin
                    n_rx_bits = bbuart_pkg::BITS_W'(bbuart_pkg::FRAME_BITS);
                    if (!r_armed) begin
                        n_armed = 1'b1;
                        n_phase = 1'b0;
                    end
                end
            end
            bbuart_pkg::FUNC_PUSH: begin
                if (!i_tx_stat.full) begin
                    tx_ctrl.push           = 1'b1;
                    o_result.push_accepted = 1'b1;
                end
                if (!r_armed) begin
                    n_armed = 1'b1;
                    n_phase = 1'b0;
                end
            end
            bbuart_pkg::FUNC_POP: begin
                if (!i_rx_stat.empty) begin
                    rx_ctrl.pop            = 1'b1;
                    o_result.rx_data       = i_rx_head;
                    o_result.rx_data_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase

        o_rx_ctrl.push = rx_ctrl.push && i_fire;
        o_rx_ctrl.pop  = rx_ctrl.pop  && i_fire;
        o_tx_ctrl.push = tx_ctrl.push && i_fire;
        o_tx_ctrl.pop  = tx_ctrl.pop  && i_fire;

        o_result.tx_level = n_tx_pin;
        o_result.busy_res = n_armed;
        o_result.rx_count = i_rx_stat.count + bbuart_pkg::COUNT_W'(rx_ctrl.push)
                            - bbuart_pkg::COUNT_W'(rx_ctrl.pop);
        o_result.tx_count = i_tx_stat.count + bbuart_pkg::COUNT_W'(tx_ctrl.push)
                            - bbuart_pkg::COUNT_W'(tx_ctrl.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_shift <= '0;
            r_rx_bits  <= '0;
            r_tx_frame <= '0;
            r_tx_bits  <= '0;
            r_tx_pin   <= 1'b1;
            r_armed    <= 1'b0;
            r_phase    <= 1'b0;
        end else if (i_fire) begin
            r_rx_shift <= n_rx_shift;
            r_rx_bits  <= n_rx_bits;
            r_tx_frame <= n_tx_frame;
            r_tx_bits  <= n_tx_bits;
            r_tx_pin   <= n_tx_pin;
            r_armed    <= n_armed;
            r_phase    <= n_phase;
        end
    end

    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> !r_phase)
        else $error("tick phase set while the timer is disarmed");

    a_rx_bits_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_bits <= bbuart_pkg::BITS_W'(bbuart_pkg::FRAME_BITS))
        else $error("receive bit count out of range");

    a_tx_bits_fifo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tx_bits != '0 |-> !i_tx_stat.empty)
        else $error("transmit frame in progress with an empty transmit FIFO");

endmodule

`default_nettype wire

// ===== src/bitbang_uart_8n1_with_fifos_top.sv =====
// Top level of the 8N1 UART channel: input item register, result register and config register.
// Instantiates bbuart_engine and two bbuart_fifo rings; depends on bbuart_pkg.
//
// Usage:
//   Input channel i_valid/o_ready carries one event per item: i_func selects a timer tick
//   (with i_rx_level), an RX falling edge, a push of i_tx_byte or a pop from the receive FIFO.
//   Output channel o_valid/i_ready returns exactly one result item per input item, in order.
//   Config channel i_cfg_valid/o_cfg_ready writes channel_open from i_cfg_data; it is always
//   ready and is meant to be written only while no item is in flight.
//   An accepted item waits in the item register until the result register is free; then it fires.
//   Throughput: one item per clock unless i_ready stalls; item and result registers form a
//   two-stage pipeline, and the FIFO head byte is prefetched from the registered memory read.
//   Reset (synchronous, active low) empties both FIFOs, idles the TX line high, disarms the
//   timer and closes the channel; FIFO memory contents are not cleared and need no sweep.
//   When the receiver stalls, the result is held and one more item can still be taken into
//   the item register; o_ready drops only when both stages are full and i_ready is low.
`default_nettype none

module bitbang_uart_8n1_with_fifos_top (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_ready,
    input  wire  [1:0]                         i_func,
    input  wire                                i_rx_level,
    input  wire  [bbuart_pkg::BYTE_W-1:0]      i_tx_byte,
    output logic                               o_valid,
    input  wire                                i_ready,
    output logic                               o_tx_level,
    output logic [bbuart_pkg::BYTE_W-1:0]      o_rx_data,
    output logic                               o_rx_data_valid,
    output logic                               o_push_accepted,
    output logic                               o_rx_frame_dropped,
    output logic                               o_busy_res,
    output logic [bbuart_pkg::COUNT_W-1:0]     o_rx_count,
    output logic [bbuart_pkg::COUNT_W-1:0]     o_tx_count,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire                                i_cfg_data
);

    logic                          r_in_valid;
    bbuart_pkg::t_func             r_func;
    logic                          r_rx_level;
    logic [bbuart_pkg::BYTE_W-1:0] r_tx_byte;
    logic                          r_open;
    logic                          r_out_valid;
    bbuart_pkg::t_result           r_res;
    logic                          out_free;
    logic                          fire;

    bbuart_pkg::t_fifo_ctrl        rx_ctrl;
    bbuart_pkg::t_fifo_ctrl        tx_ctrl;
    bbuart_pkg::t_fifo_stat        rx_stat;
    bbuart_pkg::t_fifo_stat        tx_stat;
    logic [bbuart_pkg::BYTE_W-1:0] rx_head;
    logic [bbuart_pkg::BYTE_W-1:0] tx_head;
    logic [bbuart_pkg::BYTE_W-1:0] rx_wdata;
    bbuart_pkg::t_result           res;

    assign out_free    = !r_out_valid || i_ready;
    assign fire        = r_in_valid && out_free;
    assign o_ready     = !r_in_valid || out_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_open      <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_open <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_func     <= bbuart_pkg::t_func'(i_func);
            r_rx_level <= i_rx_level;
            r_tx_byte  <= i_tx_byte;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    bbuart_fifo u_rx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (rx_ctrl),
        .i_wdata (rx_wdata),
        .o_stat  (rx_stat),
        .o_head  (rx_head)
    );

    bbuart_fifo u_tx_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (tx_ctrl),
        .i_wdata (r_tx_byte),
        .o_stat  (tx_stat),
        .o_head  (tx_head)
    );

    bbuart_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_func     (r_func),
        .i_rx_level (r_rx_level),
        .i_open     (r_open),
        .i_rx_stat  (rx_stat),
        .i_tx_stat  (tx_stat),
        .i_rx_head  (rx_head),
        .i_tx_head  (tx_head),
        .o_rx_ctrl  (rx_ctrl),
        .o_tx_ctrl  (tx_ctrl),
        .o_rx_wdata (rx_wdata),
        .o_result   (res)
    );

    assign o_valid            = r_out_valid;
    assign o_tx_level         = r_res.tx_level;
    assign o_rx_data          = r_res.rx_data;
    assign o_rx_data_valid    = r_res.rx_data_valid;
    assign o_push_accepted    = r_res.push_accepted;
    assign o_rx_frame_dropped = r_res.rx_frame_dropped;
    assign o_busy_res         = r_res.busy_res;
    assign o_rx_count         = r_res.rx_count;
    assign o_tx_count         = r_res.tx_count;

endmodule

`default_nettype wire

// ===== tb/sv/bitbang_uart_8n1_with_fifos_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bitbang_uart_8n1_with_fifos_top: tick, edge, push and pop items
// are predicted by a behavioral model of the UART channel and each result is compared by field.
// Depends on bbuart_pkg and the RTL of the top level only.
module bitbang_uart_8n1_with_fifos_top_tb;
    import bbuart_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_func                i_func;
    logic                 i_rx_level;
    logic [BYTE_W-1:0]    i_tx_byte;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_tx_level;
    logic [BYTE_W-1:0]    o_rx_data;
    logic                 o_rx_data_valid;
    logic                 o_push_accepted;
    logic                 o_rx_frame_dropped;
    logic                 o_busy_res;
    logic [COUNT_W-1:0]   o_rx_count;
    logic [COUNT_W-1:0]   o_tx_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic                 i_cfg_data;

    logic [BYTE_W-1:0]     rx_ring [FIFO_DEPTH];
    logic [BYTE_W-1:0]     tx_ring [FIFO_DEPTH];
    logic [PTR_W-1:0]      rx_rd, rx_wr, tx_rd, tx_wr;
    logic [FRAME_BITS-1:0] rx_shift, tx_frame;
    logic [BITS_W-1:0]     rx_left, tx_left;
    logic                  tx_pin, timer_armed, tick_phase, chan_open;

    t_result expected_results[$];
    t_result oldest;
    int      mismatches = 0;
    int      cycles = 0;
    int      items_sent = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;

    bitbang_uart_8n1_with_fifos_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_rx_level         (i_rx_level),
        .i_tx_byte          (i_tx_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_tx_level         (o_tx_level),
        .o_rx_data          (o_rx_data),
        .o_rx_data_valid    (o_rx_data_valid),
        .o_push_accepted    (o_push_accepted),
        .o_rx_frame_dropped (o_rx_frame_dropped),
        .o_busy_res         (o_busy_res),
        .o_rx_count         (o_rx_count),
        .o_tx_count         (o_tx_count),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic int ring_fill(input logic [PTR_W-1:0] rd, input logic [PTR_W-1:0] wr);
        return (wr >= rd) ? int'(wr) - int'(rd) : FIFO_DEPTH - int'(rd) + int'(wr);
    endfunction

    function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
        return (int'(p) == FIFO_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [COUNT_W-1:0] clamp_count(input int c);
        return (c > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(c);
    endfunction

    task automatic reset_uart_model();
        rx_rd = '0;
        rx_wr = '0;
        tx_rd = '0;
        tx_wr = '0;
        rx_shift = '0;
        tx_frame = '0;
        rx_left = '0;
        tx_left = '0;
        tx_pin = 1'b1;
        timer_armed = 1'b0;
        tick_phase = 1'b0;
        chan_open = 1'b0;
    endtask

    task automatic arm_tick_timer();
        if (!timer_armed) begin
            timer_armed = 1'b1;
            tick_phase = 1'b0;
        end
    endtask

    task automatic predict_uart_result(input t_func f, input logic lvl,
                                       input logic [BYTE_W-1:0] b, output t_result r);
        logic pending;
        r = '0;
        pending = 1'b0;
        case (f)
            FUNC_TICK: begin
                if (timer_armed) begin
                    if (chan_open) begin
                        if (!tick_phase) begin
                            if (rx_left != 0) begin
                                rx_left = rx_left - 1'b1;
                                rx_shift = {lvl, rx_shift[FRAME_BITS-1:1]};
                                if (rx_left == 0) begin
                                    if (lvl && ring_fill(rx_rd, rx_wr) < FIFO_DEPTH - 1) begin
                                        rx_ring[rx_wr] = rx_shift[BYTE_W:1];
                                        rx_wr = ring_advance(rx_wr);
                                    end else begin
                                        r.rx_frame_dropped = 1'b1;
                                    end
                                    rx_shift = '0;
                                end
                            end
                            if (tx_rd != tx_wr) begin
                                if (tx_left == 0) begin
                                    tx_frame = {1'b1, tx_ring[tx_rd], 1'b0};
                                    tx_left = BITS_W'(FRAME_BITS);
                                end
                                tx_pin = tx_frame[FRAME_BITS - int'(tx_left)];
                                tx_left = tx_left - 1'b1;
                                if (tx_left == 0) begin
                                    tx_rd = ring_advance(tx_rd);
                                end
                            end
                        end
                        pending = (rx_left != 0) || (tx_left != 0) || (tx_rd != tx_wr);
                    end
                    tick_phase = ~tick_phase;
                    if (!pending) begin
                        timer_armed = 1'b0;
                        tick_phase = 1'b0;
                    end
                end
            end
            FUNC_EDGE: begin
                if (chan_open && rx_left == 0) begin
                    rx_left = BITS_W'(FRAME_BITS);
                    arm_tick_timer();
                end
            end
            FUNC_PUSH: begin
                if (ring_fill(tx_rd, tx_wr) < FIFO_DEPTH - 1) begin
                    tx_ring[tx_wr] = b;
                    tx_wr = ring_advance(tx_wr);
                    r.push_accepted = 1'b1;
                end
                arm_tick_timer();
            end
            default: begin
                if (rx_rd != rx_wr) begin
                    r.rx_data = rx_ring[rx_rd];
                    r.rx_data_valid = 1'b1;
                    rx_rd = ring_advance(rx_rd);
                end
            end
        endcase
        r.tx_level = tx_pin;
        r.busy_res = timer_armed;
        r.rx_count = clamp_count(ring_fill(rx_rd, rx_wr));
        r.tx_count = clamp_count(ring_fill(tx_rd, tx_wr));
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] want,
                               input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result arrived with no item outstanding");
                mismatches++;
            end else begin
                oldest = expected_results.pop_front();
                check_field("tx_level", COUNT_W'(oldest.tx_level), COUNT_W'(o_tx_level));
                check_field("rx_data", COUNT_W'(oldest.rx_data), COUNT_W'(o_rx_data));
                check_field("rx_data_valid", COUNT_W'(oldest.rx_data_valid),
                            COUNT_W'(o_rx_data_valid));
                check_field("push_accepted", COUNT_W'(oldest.push_accepted),
                            COUNT_W'(o_push_accepted));
                check_field("rx_frame_dropped", COUNT_W'(oldest.rx_frame_dropped),
                            COUNT_W'(o_rx_frame_dropped));
                check_field("busy_res", COUNT_W'(oldest.busy_res), COUNT_W'(o_busy_res));
                check_field("rx_count", oldest.rx_count, o_rx_count);
                check_field("tx_count", oldest.tx_count, o_tx_count);
            end
        end
    end

    task automatic send_event(input t_func f, input logic lvl, input logic [BYTE_W-1:0] b);
        t_result r;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= f;
        i_rx_level <= lvl;
        i_tx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_uart_result(f, lvl, b, r);
        expected_results.push_back(r);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic write_channel_open(input logic value);
        wait_for_results();
        repeat (3) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        chan_open = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_noise();
        send_event(t_func'($urandom_range(3)), 1'($urandom_range(1)),
                   BYTE_W'($urandom_range(255)));
    endtask

    // Each bit is held for two ticks so that one of them lands on a sampling tick.
    task automatic receive_frame(input logic [BYTE_W-1:0] data, input logic stop_bit,
                                 input int mix_pct);
        logic [FRAME_BITS-1:0] line_bits;
        line_bits = {stop_bit, data, 1'b0};
        send_event(FUNC_EDGE, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
        for (int i = 0; i < 2 * FRAME_BITS; i++) begin
            if ($urandom_range(99) < mix_pct) begin
                send_event(t_func'($urandom_range(1, 3)), 1'($urandom_range(1)),
                           BYTE_W'($urandom_range(255)));
            end
            send_event(FUNC_TICK, line_bits[i / 2], BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic drain_line();
        while (timer_armed) begin
            send_event(FUNC_TICK, 1'b1, BYTE_W'($urandom_range(255)));
        end
    endtask

    task automatic test_closed_channel();
        send_event(FUNC_POP, 1'b1, 8'hFF);
        send_event(FUNC_TICK, 1'b1, 8'h00);
        send_event(FUNC_EDGE, 1'b0, 8'h00);
        send_event(FUNC_PUSH, 1'b0, 8'h00);
        send_event(FUNC_PUSH, 1'b1, 8'hFF);
        send_event(FUNC_TICK, 1'b0, 8'hFF);
        send_event(FUNC_TICK, 1'b1, 8'h55);
    endtask

    task automatic test_open_channel();
        send_event(FUNC_PUSH, 1'b0, 8'hA5);
        receive_frame(8'hFF, 1'b1, 0);
        receive_frame(8'h00, 1'b0, 0);
        send_event(FUNC_EDGE, 1'b1, 8'h00);
        receive_frame(8'h3C, 1'b1, 0);
        repeat (3) send_event(FUNC_POP, 1'b0, 8'hAA);
        drain_line();
    endtask

    task automatic test_fifo_limits();
        write_channel_open(1'b0);
        repeat (3) send_event(FUNC_PUSH, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
        write_channel_open(1'b1);
        repeat (2) receive_frame(BYTE_W'($urandom_range(255)), 1'b1, 0);
        repeat (4) send_event(FUNC_POP, 1'($urandom_range(1)), BYTE_W'($urandom_range(255)));
        drain_line();
    endtask

    task automatic test_random_traffic(input int budget);
        int first;
        first = items_sent;
        while (items_sent - first < budget) begin
            if ($urandom_range(99) < 70) begin
                receive_frame(BYTE_W'($urandom_range(255)), $urandom_range(99) >= 10, 15);
            end else begin
                repeat ($urandom_range(1, 6)) send_noise();
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = FUNC_TICK;
        i_rx_level = 1'b0;
        i_tx_byte = '0;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        reset_uart_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_closed_channel();
        write_channel_open(1'b1);
        test_open_channel();
        test_fifo_limits();
        test_random_traffic(60);

        sender_idle_pct = 75;
        write_channel_open(1'b0);
        test_random_traffic(30);
        write_channel_open(1'b1);
        test_random_traffic(30);

        sender_idle_pct = 0;
        receiver_stall_pct = 75;
        test_random_traffic(30);
        wait_for_results();
        test_random_traffic(30);

        sender_idle_pct = 32;
        receiver_stall_pct = 32;
        write_channel_open(1'b1);
        test_random_traffic(60);

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
